[hdl/bci_pkg.sv]
// Shared types and constants of the breakpoint curve interpolator.
`default_nettype none
package bci_pkg;

	// Bits of quotient resolved by the divider, one per stage
	localparam int DIV_BITS = 16;

	// Item handed from the multiplier stage to the divider
	typedef struct packed {
		logic [31:0]        prod;
		logic [15:0]        span;
		logic signed [15:0] vlo;
		logic               neg;
		logic               bypass;
		logic               empty;
	} mul_item_t;

	// Item carried through the divider stages
	typedef struct packed {
		logic [31:0]        rem;
		logic [15:0]        quo;
		logic [15:0]        span;
		logic signed [15:0] vlo;
		logic               neg;
		logic               bypass;
		logic               empty;
	} div_item_t;

endpackage
`default_nettype wire

[hdl/bci_front.sv]
// Breakpoint table, clamp, segment search and multiply stages.
`default_nettype none
module bci_front #(
	parameter int MAX_POINTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               req_type,
	input  wire logic [3:0]         point_index,
	input  wire logic [15:0]        point_speed,
	input  wire logic signed [15:0] point_value,
	input  wire logic [15:0]        query_speed,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_wdata,
	output logic                    mul_valid,
	input  wire logic               mul_ready,
	output bci_pkg::mul_item_t      mul_item
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SEG   = MAX_POINTS - 1;

	logic [15:0]        spd_q [MAX_POINTS];
	logic signed [15:0] val_q [MAX_POINTS];
	logic [CNT_W-1:0]   pts_q;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [15:0]        speed_s1;
	logic [CNT_W-1:0]   n_s1, n_s2;
	logic [15:0]        spd_s2;
	logic               empty_s2;
	logic [15:0]        dmag_s3, off_s3, span_s3;
	logic signed [15:0] vlo_s3;
	logic               neg_s3, byp_s3, empty_s3;
	bci_pkg::mul_item_t item_s4;

	logic rdy1, rdy2, rdy3, rdy4, acc;

	// Stage handshake: a stage loads when empty or when its successor moves
	always_comb begin
		rdy4     = !v_s4 || mul_ready;
		rdy3     = !v_s3 || rdy4;
		rdy2     = !v_s2 || rdy3;
		rdy1     = !v_s1 || rdy2;
		// hold a table write until no query is still reading the table
		in_stall = !rdy1 || (!req_type && (v_s1 || v_s2));
		acc      = in_valid && !in_stall;
	end

	// Point count register, saturated to the table depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
		end else if (cfg_we) begin
			if (int'(cfg_wdata) > MAX_POINTS) begin
				pts_q <= CNT_W'(MAX_POINTS);
			end else begin
				pts_q <= CNT_W'(cfg_wdata);
			end
		end
	end

	// Table write; drop slots beyond the depth
	always_ff @(posedge clk) begin
		if (acc && !req_type && (int'(point_index) < MAX_POINTS)) begin
			spd_q[IDX_W'(point_index)] <= point_speed;
			val_q[IDX_W'(point_index)] <= point_value;
		end
	end

	// Clamp the speed to the first and last breakpoint
	logic [15:0] last_a, clamp_a;
	always_comb begin
		last_a  = spd_q[IDX_W'(n_s1 - 1'b1)];
		clamp_a = (speed_s1 < last_a) ? speed_s1 : last_a;
		if (clamp_a < spd_q[0]) begin
			clamp_a = spd_q[0];
		end
	end

	// Find the first segment that holds the speed and form its terms
	logic [SEG-1:0]     hit_b, first_b;
	logic [15:0]        lo_b, hi_b, vl_b, vh_b;
	logic [16:0]        dv_b, ndv_b;
	logic               any_b;
	always_comb begin
		for (int k = 0; k < SEG; k++) begin
			hit_b[k] = (CNT_W'(k + 1) < n_s2) && (spd_s2 >= spd_q[k]) &&
				(spd_s2 <= spd_q[k+1]);
		end
		first_b = hit_b & (~hit_b + SEG'(1));
		any_b   = |hit_b;
		lo_b    = '0;
		hi_b    = '0;
		vl_b    = '0;
		vh_b    = '0;
		for (int k = 0; k < SEG; k++) begin
			lo_b = lo_b | ({16{first_b[k]}} & spd_q[k]);
			hi_b = hi_b | ({16{first_b[k]}} & spd_q[k+1]);
			vl_b = vl_b | ({16{first_b[k]}} & val_q[k]);
			vh_b = vh_b | ({16{first_b[k]}} & val_q[k+1]);
		end
		// no segment: give the last value in use
		if (!any_b) begin
			vl_b = val_q[IDX_W'(n_s2 - 1'b1)];
		end
		dv_b  = {vh_b[15], vh_b} - {vl_b[15], vl_b};
		ndv_b = -dv_b;
	end

	// Advance the stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= acc && req_type;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			speed_s1 <= query_speed;
			n_s1     <= pts_q;
		end
		if (rdy2) begin
			spd_s2   <= clamp_a;
			n_s2     <= n_s1;
			empty_s2 <= (n_s1 == '0);
		end
		if (rdy3) begin
			off_s3   <= spd_s2 - lo_b;
			span_s3  <= hi_b - lo_b;
			vlo_s3   <= vl_b;
			neg_s3   <= dv_b[16];
			dmag_s3  <= dv_b[16] ? ndv_b[15:0] : dv_b[15:0];
			byp_s3   <= empty_s2 || !any_b || (hi_b == lo_b);
			empty_s3 <= empty_s2;
		end
		if (rdy4) begin
			item_s4.prod   <= 32'(dmag_s3) * 32'(off_s3);
			item_s4.span   <= span_s3;
			item_s4.vlo    <= vlo_s3;
			item_s4.neg    <= neg_s3;
			item_s4.bypass <= byp_s3;
			item_s4.empty  <= empty_s3;
		end
	end

	assign mul_valid = v_s4;
	assign mul_item  = item_s4;

endmodule
`default_nettype wire

[hdl/bci_div.sv]
// Pipelined restoring divider, one quotient bit per stage, and output register.
`default_nettype none
module bci_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               mul_valid,
	output logic                    mul_ready,
	input  wire bci_pkg::mul_item_t mul_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      curve_value,
	output logic                    table_empty
);

	localparam int NB = bci_pkg::DIV_BITS;

	logic                  v_sd    [NB];
	bci_pkg::div_item_t    item_sd [NB];
	bci_pkg::div_item_t    src     [NB];
	bci_pkg::div_item_t    nxt     [NB];
	logic                  rdy     [NB];
	logic                  rdy_o;
	logic                  out_valid_q, empty_q;
	logic signed [15:0]    curve_q;
	logic [31:0]           trial;
	logic [15:0]           q_f, sq_f;
	logic signed [15:0]    val_f;

	// Ready chain from the output back to the first stage
	always_comb begin
		rdy_o      = !out_valid_q || !out_stall;
		rdy[NB-1]  = !v_sd[NB-1] || rdy_o;
		for (int j = NB - 2; j >= 0; j--) begin
			rdy[j] = !v_sd[j] || rdy[j+1];
		end
	end
	assign mul_ready = rdy[0];

	// One shift-subtract step per stage
	always_comb begin
		src[0].rem    = mul_item.prod;
		src[0].quo    = '0;
		src[0].span   = mul_item.span;
		src[0].vlo    = mul_item.vlo;
		src[0].neg    = mul_item.neg;
		src[0].bypass = mul_item.bypass;
		src[0].empty  = mul_item.empty;
		for (int j = 1; j < NB; j++) begin
			src[j] = item_sd[j-1];
		end
		trial = '0;
		for (int j = 0; j < NB; j++) begin
			nxt[j] = src[j];
			trial  = 32'(src[j].span) << (NB - 1 - j);
			if (src[j].rem >= trial) begin
				nxt[j].rem           = src[j].rem - trial;
				nxt[j].quo[NB-1-j]   = 1'b1;
			end
		end
	end

	// Apply the sign and add the lower value; an empty table gives zero, a bypass item the lower value
	always_comb begin
		q_f  = item_sd[NB-1].quo;
		sq_f = item_sd[NB-1].neg ? -q_f : q_f;
		if (item_sd[NB-1].empty) begin
			val_f = '0;
		end else if (item_sd[NB-1].bypass) begin
			val_f = item_sd[NB-1].vlo;
		end else begin
			val_f = item_sd[NB-1].vlo + signed'(sq_f);
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NB; j++) begin
				v_sd[j] <= 1'b0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (rdy[0]) v_sd[0] <= mul_valid;
			for (int j = 1; j < NB; j++) begin
				if (rdy[j]) v_sd[j] <= v_sd[j-1];
			end
			if (rdy_o) out_valid_q <= v_sd[NB-1];
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		for (int j = 0; j < NB; j++) begin
			if (rdy[j]) item_sd[j] <= nxt[j];
		end
		if (rdy_o) begin
			curve_q <= val_f;
			empty_q <= item_sd[NB-1].empty;
		end
	end

	assign out_valid   = out_valid_q;
	assign curve_value = curve_q;
	assign table_empty = empty_q;

endmodule
`default_nettype wire

[hdl/breakpoint_curve_interpolator_core.sv]
// Top level of the breakpoint curve interpolator.
//
//  channel   direction  handshake            payload
//  in        receive    in_valid/in_stall    req_type point_index point_speed
//                                            point_value query_speed
//  out       send       out_valid/out_stall  curve_value table_empty
//  cfg       receive    cfg_we               cfg_wdata (points_in_use)
//
// One item enters per cycle while in_stall is low; a query's result passes through
// the input register, clamp, search, multiply, 16 divider stages and output
// register on its way to the output.
// A write item is held while a query sits in the two table-reading stages.
// Each stage moves when its successor frees, so bubbles close up under stall.
// Reset clears valid bits and the point count; the table is not cleared.
`default_nettype none
module breakpoint_curve_interpolator_core #(
	parameter int MAX_POINTS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               req_type,
	input  wire logic [3:0]         point_index,
	input  wire logic [15:0]        point_speed,
	input  wire logic signed [15:0] point_value,
	input  wire logic [15:0]        query_speed,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      curve_value,
	output logic                    table_empty,
	input  wire logic               cfg_we,
	input  wire logic [4:0]         cfg_wdata
);

	logic               mul_valid, mul_ready;
	bci_pkg::mul_item_t mul_item;

	bci_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .point_index(point_index),
		.point_speed(point_speed), .point_value(point_value),
		.query_speed(query_speed),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.mul_valid(mul_valid), .mul_ready(mul_ready), .mul_item(mul_item)
	);

	bci_div u_div (
		.clk(clk), .arst_n(arst_n),
		.mul_valid(mul_valid), .mul_ready(mul_ready), .mul_item(mul_item),
		.out_valid(out_valid), .out_stall(out_stall),
		.curve_value(curve_value), .table_empty(table_empty)
	);

endmodule
`default_nettype wire

[hdl/bci_checker.sv]
// Port-level checks of the breakpoint curve interpolator and their binding.
`default_nettype none
module bci_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               req_type,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] curve_value,
	input wire logic               table_empty
);

	// A stalled result item stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(curve_value) &&
		$stable(table_empty))
		else $error("stalled result item changed");

	// An empty table answers zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_empty |-> curve_value == 16'sd0)
		else $error("empty table gave a nonzero value");

	// With the output free, only a held table write stalls the input
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall && (!out_valid || !out_stall) |-> !req_type)
		else $error("input stalled with a free output");

endmodule

bind breakpoint_curve_interpolator_core bci_checker u_bci_checker (.*);
`default_nettype wire
